// ===== sv/sot_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and control/status types for the stream ownership table.
package sot_pkg;

    localparam int DOMAIN_COUNT_DEF = 8;
    localparam int SLOT_COUNT_DEF   = 32;

    localparam int CMD_W   = 3;
    localparam int DOMID_W = 8;
    localparam int ROOT_W  = 64;
    localparam int IPAW_W  = 7;
    localparam int SID_W   = 32;
    localparam int ST_W    = 3;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;

    localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ASSIGN   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNASSIGN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOVE     = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_BUSY      = 3'd3;
    localparam logic [ST_W-1:0] ST_NODEV     = 3'd4;
    localparam logic [ST_W-1:0] ST_NOT_OWNER = 3'd5;
    localparam logic [ST_W-1:0] ST_CONFLICT  = 3'd6;

    localparam logic REG_HW_READY = 1'b0;
    localparam logic REG_INV_CODE = 1'b1;

    typedef struct packed {
        logic            clear;
        logic            cap;
        logic            set_src;
        logic            set_tgt;
        logic            start_scan;
        logic            destroy;
        logic            cre_wr;
        logic            dom_free;
        logic            eval_asg;
        logic            eval_una;
        logic            load_out;
        logic [ST_W-1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic             clr_last;
        logic             scan_done;
        logic             dom_ok;
        logic             sid_bad;
        logic             cre_bad;
        logic             cre_used;
        logic             cre_match;
        logic [ST_W-1:0]  asg_st;
        logic [ST_W-1:0]  una_st;
        logic             out_free;
        logic [CMD_W-1:0] command;
        logic             tpres;
        logic             spres;
    } t_sts;

endpackage

// ===== sv/sot_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: captured command, domain table, slot table memory, scan logic and result register.
module sot_dpath #(
    parameter int DOMAIN_COUNT = sot_pkg::DOMAIN_COUNT_DEF,
    parameter int SLOT_COUNT   = sot_pkg::SLOT_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sot_pkg::t_cmd               i_cmd,
    output sot_pkg::t_sts               o_sts,
    input  logic [sot_pkg::CMD_W-1:0]   i_command,
    input  logic [sot_pkg::DOMID_W-1:0] i_domain_id,
    input  logic                        i_target_present,
    input  logic [sot_pkg::DOMID_W-1:0] i_source_domain_id,
    input  logic                        i_source_present,
    input  logic [sot_pkg::ROOT_W-1:0]  i_root_table_addr,
    input  logic [sot_pkg::IPAW_W-1:0]  i_ipa_width,
    input  logic [sot_pkg::SID_W-1:0]   i_stream_id,
    input  logic                        i_hw_ready,
    input  logic [sot_pkg::SID_W-1:0]   i_inv_code,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [sot_pkg::ST_W-1:0]    o_status
);

    localparam int DOM_W  = (DOMAIN_COUNT > 1) ? $clog2(DOMAIN_COUNT) : 1;
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ENT_W  = 2 + sot_pkg::DOMID_W + sot_pkg::SID_W;
    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [sot_pkg::DOMID_W:0] DC_LIM = (sot_pkg::DOMID_W + 1)'(DOMAIN_COUNT);

    // captured item
    logic [sot_pkg::CMD_W-1:0]   r_command;
    logic [sot_pkg::DOMID_W-1:0] r_dom;
    logic                        r_tpres;
    logic [sot_pkg::DOMID_W-1:0] r_src;
    logic                        r_spres;
    logic [sot_pkg::ROOT_W-1:0]  r_root;
    logic [sot_pkg::IPAW_W-1:0]  r_width;
    logic [sot_pkg::SID_W-1:0]   r_sid;
    logic [sot_pkg::DOMID_W-1:0] r_cur_dom;
    logic                        r_cur_pres;

    // domain table
    logic [sot_pkg::ROOT_W-1:0]  r_droot_mem [DOMAIN_COUNT];
    logic [sot_pkg::IPAW_W-1:0]  r_dwid_mem  [DOMAIN_COUNT];
    logic [sot_pkg::ROOT_W-1:0]  r_droot;
    logic [sot_pkg::IPAW_W-1:0]  r_dwid;
    logic [DOMAIN_COUNT-1:0]     r_dom_used;

    // slot table: {used, owner_valid, owner, stream}
    logic [ENT_W-1:0]  r_slot_mem [SLOT_COUNT];
    logic [ENT_W-1:0]  r_rd_data;
    logic [SLOT_W-1:0] r_scan_idx;
    logic [SLOT_W-1:0] r_rd_idx;
    logic              r_issue;
    logic              r_rd_vld;
    logic              r_destroy;

    logic                        r_hit;
    logic [SLOT_W-1:0]           r_hit_idx;
    logic                        r_hit_ov;
    logic [sot_pkg::DOMID_W-1:0] r_hit_own;
    logic                        r_free;
    logic [SLOT_W-1:0]           r_free_idx;

    logic                      r_out_valid;
    logic [sot_pkg::ST_W-1:0]  r_status;

    logic                        w_used;
    logic                        w_ov;
    logic [sot_pkg::DOMID_W-1:0] w_own;
    logic [sot_pkg::SID_W-1:0]   w_sid;
    logic                        w_cur_in_range;
    logic                        w_dom_in_range;
    logic                        w_kill;
    logic [SLOT_W-1:0]           w_asg_idx;
    logic                        w_asg_we;
    logic [ENT_W-1:0]            w_asg_data;
    logic [sot_pkg::ST_W-1:0]    w_asg_st;
    logic                        w_una_we;
    logic [sot_pkg::ST_W-1:0]    w_una_st;
    logic                        w_we;
    logic [SLOT_W-1:0]           w_waddr;
    logic [ENT_W-1:0]            w_wdata;

    assign w_used = r_rd_data[ENT_W-1];
    assign w_ov   = r_rd_data[ENT_W-2];
    assign w_own  = r_rd_data[sot_pkg::SID_W +: sot_pkg::DOMID_W];
    assign w_sid  = r_rd_data[sot_pkg::SID_W-1:0];

    assign w_cur_in_range = ({1'b0, r_cur_dom} < DC_LIM);
    assign w_dom_in_range = ({1'b0, r_dom} < DC_LIM);
    assign w_kill = r_rd_vld && r_destroy && w_used && w_ov && (w_own == r_cur_dom);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_command  <= i_command;
            r_dom      <= i_domain_id;
            r_tpres    <= i_target_present;
            r_src      <= i_source_domain_id;
            r_spres    <= i_source_present;
            r_root     <= i_root_table_addr;
            r_width    <= i_ipa_width;
            r_sid      <= i_stream_id;
            r_cur_dom  <= i_domain_id;
            r_cur_pres <= i_target_present;
            r_droot    <= r_droot_mem[i_domain_id[DOM_W-1:0]];
            r_dwid     <= r_dwid_mem[i_domain_id[DOM_W-1:0]];
        end else if (i_cmd.set_src) begin
            r_cur_dom  <= r_src;
            r_cur_pres <= 1'b1;
        end else if (i_cmd.set_tgt) begin
            r_cur_dom  <= r_dom;
            r_cur_pres <= 1'b1;
        end
        if (i_cmd.cre_wr) begin
            r_droot_mem[r_dom[DOM_W-1:0]] <= r_root;
            r_dwid_mem[r_dom[DOM_W-1:0]]  <= r_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dom_used <= '0;
        end else if (i_cmd.cre_wr) begin
            r_dom_used[r_dom[DOM_W-1:0]] <= 1'b1;
        end else if (i_cmd.dom_free) begin
            r_dom_used[r_cur_dom[DOM_W-1:0]] <= 1'b0;
        end
    end

    always_comb begin
        w_asg_idx  = r_hit ? r_hit_idx : r_free_idx;
        w_asg_st   = sot_pkg::ST_OK;
        w_asg_we   = 1'b0;
        w_asg_data = {1'b1, 1'b1, r_cur_dom, r_sid};
        if (!(r_hit || r_free)) begin
            w_asg_st = sot_pkg::ST_FULL;
        end else if (r_hit && r_hit_ov && (r_hit_own != r_cur_dom)) begin
            w_asg_st = sot_pkg::ST_BUSY;
        end else if (!i_hw_ready) begin
            w_asg_st   = sot_pkg::ST_NODEV;
            w_asg_we   = 1'b1;
            w_asg_data = '0;
        end else begin
            w_asg_we = 1'b1;
        end
    end

    always_comb begin
        w_una_st = sot_pkg::ST_OK;
        w_una_we = 1'b0;
        if (!r_hit) begin
            w_una_st = sot_pkg::ST_NODEV;
        end else if (!r_hit_ov || (r_hit_own != r_cur_dom)) begin
            w_una_st = sot_pkg::ST_NOT_OWNER;
        end else if (!i_hw_ready) begin
            w_una_st = sot_pkg::ST_NODEV;
        end else begin
            w_una_we = 1'b1;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_scan_idx;
        w_wdata = '0;
        if (i_cmd.clear) begin
            w_we = 1'b1;
        end else if (w_kill) begin
            w_we    = 1'b1;
            w_waddr = r_rd_idx;
        end else if (i_cmd.eval_asg && w_asg_we) begin
            w_we    = 1'b1;
            w_waddr = w_asg_idx;
            w_wdata = w_asg_data;
        end else if (i_cmd.eval_una && w_una_we) begin
            w_we    = 1'b1;
            w_waddr = r_hit_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_slot_mem[w_waddr] <= w_wdata;
        end
        if (r_issue) begin
            r_rd_data <= r_slot_mem[r_scan_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_issue    <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
            r_destroy  <= 1'b0;
        end else begin
            r_rd_vld <= r_issue;
            r_rd_idx <= r_scan_idx;
            if (i_cmd.start_scan) begin
                r_scan_idx <= '0;
                r_issue    <= 1'b1;
                r_hit      <= 1'b0;
                r_free     <= 1'b0;
                r_destroy  <= i_cmd.destroy;
            end else if (r_issue || i_cmd.clear) begin
                if (r_scan_idx == LAST) begin
                    r_scan_idx <= '0;
                    r_issue    <= 1'b0;
                end else begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
            end
            if (r_rd_vld && w_used && (w_sid == r_sid) && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_idx;
                r_hit_ov  <= w_ov;
                r_hit_own <= w_own;
            end
            if (r_rd_vld && !w_used && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_status <= i_cmd.out_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    always_comb begin
        o_sts.clr_last  = (r_scan_idx == LAST);
        o_sts.scan_done = r_rd_vld && (r_rd_idx == LAST);
        o_sts.dom_ok    = r_cur_pres && w_cur_in_range && r_dom_used[r_cur_dom[DOM_W-1:0]];
        o_sts.sid_bad   = (r_sid == i_inv_code);
        o_sts.cre_bad   = !w_dom_in_range || (r_root == '0);
        o_sts.cre_used  = r_dom_used[r_dom[DOM_W-1:0]];
        o_sts.cre_match = (r_droot == r_root) && (r_dwid == r_width);
        o_sts.asg_st    = w_asg_st;
        o_sts.una_st    = w_una_st;
        o_sts.out_free  = !r_out_valid || i_out_ready;
        o_sts.command   = r_command;
        o_sts.tpres     = r_tpres;
        o_sts.spres     = r_spres;
    end

endmodule

// ===== sv/sot_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences clearing, checks, slot scans, updates and result hand-off.
module sot_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sot_pkg::t_sts i_sts,
    output sot_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DOM   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_EVAL  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic                     r_phase;  // 1: assign, 0: unassign
    logic                     n_phase;
    logic [sot_pkg::ST_W-1:0] r_status;
    logic [sot_pkg::ST_W-1:0] n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
        r_phase  <= n_phase;
        r_status <= n_status;
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.out_status = r_status;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DOM;
                end
            end
            S_DOM: begin
                n_state = S_DONE;
                case (i_sts.command)
                    sot_pkg::CMD_CREATE: begin
                        if (i_sts.cre_bad) begin
                            n_status = sot_pkg::ST_INVALID;
                        end else if (!i_sts.cre_used) begin
                            o_cmd.cre_wr = 1'b1;
                            n_status     = sot_pkg::ST_OK;
                        end else if (i_sts.cre_match) begin
                            n_status = sot_pkg::ST_OK;
                        end else begin
                            n_status = sot_pkg::ST_CONFLICT;
                        end
                    end
                    sot_pkg::CMD_DESTROY: begin
                        if (!i_sts.dom_ok) begin
                            n_status = sot_pkg::ST_INVALID;
                        end else begin
                            o_cmd.start_scan = 1'b1;
                            o_cmd.destroy    = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    sot_pkg::CMD_ASSIGN: begin
                        n_phase = 1'b1;
                        n_state = S_CHK;
                    end
                    sot_pkg::CMD_UNASSIGN: begin
                        n_phase = 1'b0;
                        n_state = S_CHK;
                    end
                    sot_pkg::CMD_MOVE: begin
                        if (i_sts.spres) begin
                            o_cmd.set_src = 1'b1;
                            n_phase       = 1'b0;
                            n_state       = S_CHK;
                        end else if (i_sts.tpres) begin
                            n_phase = 1'b1;
                            n_state = S_CHK;
                        end else begin
                            n_status = sot_pkg::ST_OK;
                        end
                    end
                    default: begin
                        n_status = sot_pkg::ST_INVALID;
                    end
                endcase
            end
            S_CHK: begin
                if (!i_sts.dom_ok || i_sts.sid_bad) begin
                    n_status = sot_pkg::ST_INVALID;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.start_scan = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_DONE;
                if (i_sts.command == sot_pkg::CMD_DESTROY) begin
                    o_cmd.dom_free = 1'b1;
                    n_status       = sot_pkg::ST_OK;
                end else if (r_phase) begin
                    o_cmd.eval_asg = 1'b1;
                    n_status       = i_sts.asg_st;
                end else begin
                    o_cmd.eval_una = 1'b1;
                    n_status       = i_sts.una_st;
                    if (i_sts.command == sot_pkg::CMD_MOVE && i_sts.tpres &&
                        i_sts.una_st == sot_pkg::ST_OK) begin
                        o_cmd.set_tgt = 1'b1;
                        n_phase       = 1'b1;
                        n_state       = S_CHK;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/stream_ownership_table_unit.sv =====
`timescale 1ns / 1ps
// Top level: stream ownership table with configuration registers.
// Create, unknown commands, a rejected destroy and an empty move finish without a slot scan;
// a rejected assign/unassign adds a check step; destroy, assign and unassign scan the slot
// table once, a move up to twice (one slot table read per cycle).
// Throughput: one item in flight; a stalled result adds its wait.
// Reset: synchronous; hardware_ready 0, invalid code all ones; then a clearing pass over the slot table.
module stream_ownership_table_unit #(
    parameter int DOMAIN_COUNT = sot_pkg::DOMAIN_COUNT_DEF,
    parameter int SLOT_COUNT   = sot_pkg::SLOT_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sot_pkg::CMD_W-1:0]   i_command,
    input  logic [sot_pkg::DOMID_W-1:0] i_domain_id,
    input  logic                        i_target_present,
    input  logic [sot_pkg::DOMID_W-1:0] i_source_domain_id,
    input  logic                        i_source_present,
    input  logic [sot_pkg::ROOT_W-1:0]  i_root_table_addr,
    input  logic [sot_pkg::IPAW_W-1:0]  i_ipa_width,
    input  logic [sot_pkg::SID_W-1:0]   i_stream_id,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sot_pkg::ST_W-1:0]    o_status,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sot_pkg::CFG_AW-1:0]  paddr,
    input  logic [sot_pkg::CFG_DW-1:0]  pwdata,
    output logic [sot_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);

    logic                      r_hw_ready;
    logic [sot_pkg::SID_W-1:0] r_inv_code;
    sot_pkg::t_cmd             w_cmd;
    sot_pkg::t_sts             w_sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw_ready <= 1'b0;
            r_inv_code <= '1;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                sot_pkg::REG_HW_READY: r_hw_ready <= pwdata[0];
                sot_pkg::REG_INV_CODE: r_inv_code <= pwdata[sot_pkg::SID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            sot_pkg::REG_HW_READY: prdata = {{(sot_pkg::CFG_DW-1){1'b0}}, r_hw_ready};
            sot_pkg::REG_INV_CODE: prdata = r_inv_code;
            default:               prdata = '0;
        endcase
    end

    sot_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    sot_dpath #(
        .DOMAIN_COUNT (DOMAIN_COUNT),
        .SLOT_COUNT   (SLOT_COUNT)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_command          (i_command),
        .i_domain_id        (i_domain_id),
        .i_target_present   (i_target_present),
        .i_source_domain_id (i_source_domain_id),
        .i_source_present   (i_source_present),
        .i_root_table_addr  (i_root_table_addr),
        .i_ipa_width        (i_ipa_width),
        .i_stream_id        (i_stream_id),
        .i_hw_ready         (r_hw_ready),
        .i_inv_code         (r_inv_code),
        .i_out_ready        (i_ready),
        .o_out_valid        (o_valid),
        .o_status           (o_status)
    );

endmodule

// ===== sv/sot_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the stream ownership table, bound to the top level.
module sot_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic [sot_pkg::ST_W-1:0] o_status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result changed while stalled");

    // one item in flight: no back-to-back transfers in
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second transfer accepted while busy");

    // a new result only appears while an item is being worked on
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared without an item in work");

    // reset empties the output and blocks input during the clearing pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("outputs active after reset");

endmodule

bind stream_ownership_table_unit sot_checker u_sot_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_status (o_status)
);
